@@ hdl/ptypa_pkg.sv @@
// Package for the point to yaw / pitch angle unit.
// Widths, payload structs, CORDIC angle table and angle rounding helper.
// No dependencies.
package ptypa_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int YAW_W    = 16;
  localparam int PITCH_W  = 14;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LASER_HEIGHT = CFG_IDX_W'(1);

  localparam int HEIGHT_W = COORD_WIDTH - 1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1600);

  // vy and the pre-rotated operands need two bits over the coordinate
  localparam int VW = COORD_WIDTH + 2;
  localparam int PRESCALE_SH = 12;
  // datapath: pre-rotated operand, prescale and CORDIC growth
  localparam int DW = COORD_WIDTH + 16;
  localparam int ZW = 24;
  localparam int SHW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  localparam int ANG_SH   = 8;
  localparam int ANG_HALF = 128;
  localparam int RW = ZW + 1 - ANG_SH;

  localparam int DEG90       = 2949120;
  localparam int YAW_LIMIT   = 23040;
  localparam int PITCH_LIMIT = 11520;

  localparam int GAIN_W   = 16;
  localparam int INV_GAIN = 39797;
  localparam int PW = DW + GAIN_W;

  localparam int ATAN_TAB [32] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } in_t;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw_angle;
    logic [PITCH_W-1:0]      pitch_angle;
  } out_t;

  typedef struct packed {
    logic                    x_zero;
    logic                    x_pos;
    logic                    vy_neg;
    logic                    vy_zero;
    logic signed [YAW_W-1:0] yaw;
  } side_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cordic_t;

  typedef struct packed {
    logic [PW-1:0] prod;
    side_t         side;
  } gain_t;

  function automatic logic signed [RW-1:0] round_angle(logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    t = (ZW+1)'(z) + (ZW+1)'(ANG_HALF);
    return RW'(t >>> ANG_SH);
  endfunction

endpackage

@@ hdl/ptypa_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on ptypa_pkg.
module ptypa_cordic_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [ptypa_pkg::SHW-1:0] shift_i,
  input  logic [ptypa_pkg::ZW-1:0]  atan_i,
  input  ptypa_pkg::cordic_t      data_i,
  output logic                    valid_o,
  output ptypa_pkg::cordic_t      data_o
);
  import ptypa_pkg::*;

  logic signed [DW-1:0] x, y, dx, dy;
  logic signed [ZW-1:0] z, at;
  cordic_t data_d, data_q;
  logic valid_q;

  always_comb begin
    x  = data_i.x;
    y  = data_i.y;
    z  = data_i.z;
    at = $signed(atan_i);
    dx = y >>> shift_i;
    dy = x >>> shift_i;
    data_d = data_i;
    if (!y[DW-1]) begin
      data_d.x = x + dx;
      data_d.y = y - dy;
      data_d.z = z + at;
    end else begin
      data_d.x = x - dx;
      data_d.y = y + dy;
      data_d.z = z - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/ptypa_gain.sv @@
// Yaw finish and CORDIC gain correction stage between the two cell chains.
// Depends on ptypa_pkg.
module ptypa_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ptypa_pkg::cordic_t data_i,
  output logic               valid_o,
  output ptypa_pkg::gain_t   data_o
);
  import ptypa_pkg::*;

  localparam logic signed [RW-1:0] YAW_MAX_R = RW'(YAW_LIMIT);
  localparam logic signed [RW-1:0] YAW_MIN_R = RW'(-YAW_LIMIT);

  logic [DW-1:0] mag;
  logic signed [RW-1:0] ang;
  logic signed [YAW_W-1:0] yaw;
  gain_t data_d, data_q;
  logic valid_q;

  always_comb begin
    mag = data_i.x[DW-1] ? '0 : data_i.x;
    ang = round_angle(data_i.z);
    if (data_i.side.x_zero) begin
      yaw = data_i.side.vy_neg ? YAW_W'(YAW_LIMIT) : '0;
    end else if (data_i.side.vy_zero) begin
      yaw = data_i.side.x_pos ? YAW_W'(PITCH_LIMIT) : YAW_W'(-PITCH_LIMIT);
    end else if (ang < YAW_MIN_R) begin
      yaw = YAW_W'(-YAW_LIMIT);
    end else if (ang > YAW_MAX_R) begin
      yaw = YAW_W'(YAW_LIMIT);
    end else begin
      yaw = YAW_W'(ang);
    end
    data_d.prod     = PW'(mag) * PW'(INV_GAIN);
    data_d.side     = data_i.side;
    data_d.side.yaw = yaw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/point_to_yaw_pitch_angles_unit.sv @@
// Point to yaw / pitch angle unit: configuration registers, pre-rotation,
// two chains of CORDIC cells joined by the gain stage, output register.
// Depends on ptypa_pkg, ptypa_cordic_cell and ptypa_gain.
//
// Takes one point per cycle while input ready is high. A point passes, in
// order, through one cell per CORDIC micro-rotation in the yaw chain, the
// gain stage, one cell per micro-rotation in the pitch chain and the output
// register. While a result waits, the chains advance until the last pitch
// cell is full; input ready drops only when the output register is held and
// the last pitch cell is full. Angles are in 1/128 degree. Configuration
// writes are always taken and belong to idle periods.
module point_to_yaw_pitch_angles_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ptypa_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ptypa_pkg::out_t               out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptypa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptypa_pkg::COORD_WIDTH-1:0] cfg_data_i
);
  import ptypa_pkg::*;

  localparam logic signed [RW-1:0] PITCH_MAX_R = RW'(PITCH_LIMIT);

  logic signed [COORD_WIDTH-1:0] y_offset_q;
  logic [HEIGHT_W-1:0] laser_height_q;

  logic en;
  logic signed [VW-1:0] xv, vy, cx, cy;
  logic signed [ZW-1:0] z0;
  cordic_t yaw_in;
  cordic_t pit_in;

  cordic_t yaw_c [CORDIC_STAGES+1];
  logic    yaw_v [CORDIC_STAGES+1];
  cordic_t pit_c [CORDIC_STAGES+1];
  logic    pit_v [CORDIC_STAGES+1];

  gain_t gain_q;
  logic gain_v;
  logic [PW:0] dist_sum;

  logic signed [RW-1:0] pang;
  logic [PITCH_W-1:0] pitch;
  out_t out_q;
  logic out_valid_q;
  cordic_t last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_offset_q     <= '0;
      laser_height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_Y_OFFSET:     y_offset_q <= $signed(cfg_data_i);
        CFG_LASER_HEIGHT: laser_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign last = pit_c[CORDIC_STAGES];
  assign en = !(pit_v[CORDIC_STAGES] && out_valid_q && !out_ready_i);
  assign in_ready_o = en;

  // pre-rotation of the left half plane, then prescale
  always_comb begin
    xv = VW'(in_data_i.x_coord);
    vy = VW'(in_data_i.y_coord) + VW'(y_offset_q);
    if (vy[VW-1]) begin
      if (!xv[VW-1]) begin
        cx = xv;
        cy = -vy;
        z0 = ZW'(DEG90);
      end else begin
        cx = -xv;
        cy = vy;
        z0 = ZW'(-DEG90);
      end
    end else begin
      cx = vy;
      cy = xv;
      z0 = '0;
    end
    yaw_in.x = DW'(cx) <<< PRESCALE_SH;
    yaw_in.y = DW'(cy) <<< PRESCALE_SH;
    yaw_in.z = z0;
    yaw_in.side.x_zero  = (in_data_i.x_coord == '0);
    yaw_in.side.x_pos   = !in_data_i.x_coord[COORD_WIDTH-1] && (in_data_i.x_coord != '0);
    yaw_in.side.vy_neg  = vy[VW-1];
    yaw_in.side.vy_zero = (vy == '0);
    yaw_in.side.yaw     = '0;
  end

  assign yaw_c[0] = yaw_in;
  assign yaw_v[0] = in_valid_i;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_yaw
    ptypa_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (yaw_v[g]),
      .shift_i (SHW'(g)),
      .atan_i  (ZW'(ATAN_TAB[g])),
      .data_i  (yaw_c[g]),
      .valid_o (yaw_v[g+1]),
      .data_o  (yaw_c[g+1])
    );
  end

  ptypa_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (yaw_v[CORDIC_STAGES]),
    .data_i  (yaw_c[CORDIC_STAGES]),
    .valid_o (gain_v),
    .data_o  (gain_q)
  );

  always_comb begin
    dist_sum = (PW+1)'(gain_q.prod) + (PW+1)'(32768);
    pit_in.x    = $signed(dist_sum[GAIN_W +: DW]);
    pit_in.y    = $signed(DW'(laser_height_q) << PRESCALE_SH);
    pit_in.z    = '0;
    pit_in.side = gain_q.side;
  end

  assign pit_c[0] = pit_in;
  assign pit_v[0] = gain_v;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
    ptypa_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pit_v[g]),
      .shift_i (SHW'(g)),
      .atan_i  (ZW'(ATAN_TAB[g])),
      .data_i  (pit_c[g]),
      .valid_o (pit_v[g+1]),
      .data_o  (pit_c[g+1])
    );
  end

  always_comb begin
    pang = round_angle(last.z);
    if (laser_height_q == '0) begin
      pitch = '0;
    end else if (last.side.x_zero && last.side.vy_zero) begin
      pitch = PITCH_W'(PITCH_LIMIT);
    end else if (pang[RW-1]) begin
      pitch = '0;
    end else if (pang > PITCH_MAX_R) begin
      pitch = PITCH_W'(PITCH_LIMIT);
    end else begin
      pitch = PITCH_W'(pang);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && pit_v[CORDIC_STAGES]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && pit_v[CORDIC_STAGES]) begin
      out_q.yaw_angle   <= last.side.yaw;
      out_q.pitch_angle <= pitch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/ptypa_angle_checker.sv @@
// Checker for the point to yaw / pitch angle unit: follows the config writes,
// predicts the angles of each accepted point and compares every result beat.
// Depends on ptypa_pkg.
module ptypa_angle_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  ptypa_pkg::in_t                    in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  ptypa_pkg::out_t                   out_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [ptypa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptypa_pkg::COORD_WIDTH-1:0] cfg_data_i,
  output int                                pending_o,
  output int                                fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptypa_pkg::*;

  typedef struct packed {
    longint x;
    longint z;
  } axis_t;

  out_t   expected_angles_q [$];
  out_t   oldest;
  longint offset_q;
  longint height_q;
  int     fail_n = 0;

  function automatic axis_t rotate_onto_axis(longint x, longint y, longint z);
    longint dx;
    longint dy;
    axis_t  r;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end
    end
    r.x = x;
    r.z = z;
    return r;
  endfunction

  function automatic longint angle_out(longint z, longint lo, longint hi);
    longint a;
    a = (z + ANG_HALF) >>> ANG_SH;
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    return a;
  endfunction

  function automatic out_t predict_angles(in_t p, longint offset, longint height);
    longint xc, vy, cx, cy, z, mag, planar_len, yaw, pitch;
    axis_t  yv;
    axis_t  pv;
    out_t   r;
    xc = longint'($signed(p.x_coord));
    vy = longint'($signed(p.y_coord)) + offset;
    // left half plane: turn by 90 degrees first
    if (vy < 0) begin
      if (xc >= 0) begin
        cx = xc;
        cy = -vy;
        z  = DEG90;
      end else begin
        cx = -xc;
        cy = vy;
        z  = -DEG90;
      end
    end else begin
      cx = vy;
      cy = xc;
      z  = 0;
    end
    yv  = rotate_onto_axis(cx <<< PRESCALE_SH, cy <<< PRESCALE_SH, z);
    mag = (yv.x < 0) ? 0 : yv.x;
    if (xc == 0) yaw = (vy < 0) ? YAW_LIMIT : 0;
    else if (vy == 0) yaw = (xc > 0) ? PITCH_LIMIT : -PITCH_LIMIT;
    else yaw = angle_out(yv.z, -YAW_LIMIT, YAW_LIMIT);
    planar_len = (mag * INV_GAIN + (longint'(1) << (GAIN_W - 1))) >>> GAIN_W;
    if (height == 0) begin
      pitch = 0;
    end else if (xc == 0 && vy == 0) begin
      pitch = PITCH_LIMIT;
    end else begin
      pv    = rotate_onto_axis(planar_len, height <<< PRESCALE_SH, 0);
      pitch = angle_out(pv.z, 0, PITCH_LIMIT);
    end
    r.yaw_angle   = yaw[YAW_W-1:0];
    r.pitch_angle = pitch[PITCH_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_angles_q.delete();
      offset_q = 0;
      height_q = longint'(HEIGHT_RESET);
      pending_o    <= 0;
      fail_count_o <= fail_n;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_Y_OFFSET:     offset_q = longint'($signed(cfg_data_i));
          CFG_LASER_HEIGHT: height_q = longint'(cfg_data_i[HEIGHT_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_angles_q.size() == 0) begin
          $error("result beat with no point waiting: yaw_angle %0d pitch_angle %0d",
                 out_data_i.yaw_angle, out_data_i.pitch_angle);
          fail_n++;
        end else begin
          oldest = expected_angles_q.pop_front();
          if (out_data_i.yaw_angle !== oldest.yaw_angle) begin
            $error("yaw_angle: expected %0d, got %0d", oldest.yaw_angle,
                   out_data_i.yaw_angle);
            fail_n++;
          end
          if (out_data_i.pitch_angle !== oldest.pitch_angle) begin
            $error("pitch_angle: expected %0d, got %0d", oldest.pitch_angle,
                   out_data_i.pitch_angle);
            fail_n++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_angles_q.push_back(predict_angles(in_data_i, offset_q, height_q));
      pending_o    <= expected_angles_q.size();
      fail_count_o <= fail_n;
    end
  end

endmodule

@@ tb/sv/point_to_yaw_pitch_angles_unit_test.sv @@
// Testbench top for the point to yaw / pitch angle unit: clock, reset, point
// and config stimulus, receiver stalls and the verdict.
// Depends on ptypa_pkg, point_to_yaw_pitch_angles_unit and ptypa_angle_checker.
module point_to_yaw_pitch_angles_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptypa_pkg::*;

  localparam int N_PHASES       = 8;
  localparam int POINTS_PER_PHASE = 175;
  localparam int N_DIRECTED     = 24;
  localparam int LATENCY        = 2 * CORDIC_STAGES + 2;
  localparam int HOLD_CYCLES    = 200;
  localparam int CYCLE_LIMIT    = 1000000;
  // unmapped indexes, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = '1;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_t                   out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;
  int                     pending;
  int                     fail_count;

  bit  hold_off_req  = 1'b0;
  bit  steady_sink   = 1'b0;
  bit  steady_source = 1'b0;
  int  cycle_count   = 0;

  logic [COORD_WIDTH-1:0] phase_offset [N_PHASES];
  logic [COORD_WIDTH-1:0] phase_height [N_PHASES];

  int dir_x [N_DIRECTED] = '{0, 0, 0, 100, -100, 100, -100, 100, -100, 1, -1, 32767,
                             -32768, 32767, -32768, 1, -1, 1, 32767, -32768, 0, 0,
                             32767, -32768};
  int dir_y [N_DIRECTED] = '{0, 100, -100, 0, 0, 100, 100, -100, -100, -32768, -32768,
                             32767, -32768, -32768, 32767, 1, -1, 32767, 1, 1, 32767,
                             -32768, 0, 0};

  point_to_yaw_pitch_angles_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ptypa_angle_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t random_point(logic [COORD_WIDTH-1:0] offset);
    in_t p;
    p.x_coord = COORD_WIDTH'($urandom);
    p.y_coord = COORD_WIDTH'($urandom);
    case ($urandom_range(0, 15))
      0: p.x_coord = '0;
      1: p.y_coord = -offset;
      2: begin
        p.x_coord = '0;
        p.y_coord = -offset;
      end
      3: p.x_coord = $urandom_range(0, 1) ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                          : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      4: p.y_coord = $urandom_range(0, 1) ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                          : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      5: p.x_coord = COORD_WIDTH'($urandom_range(0, 16)) - COORD_WIDTH'(8);
      6: p.y_coord = -offset + (COORD_WIDTH'($urandom_range(0, 16)) - COORD_WIDTH'(8));
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_point(input in_t p);
    int unsigned gap;
    gap = steady_source ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COORD_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        out_ready   <= 1'b0;
      end else if (steady_sink || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_t p;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    phase_offset[0] = '0;
    phase_height[0] = COORD_WIDTH'(HEIGHT_RESET);
    phase_offset[1] = '0;
    phase_height[1] = '0;
    phase_offset[2] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    phase_height[2] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    phase_offset[3] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    phase_height[3] = COORD_WIDTH'(1);
    phase_offset[4] = COORD_WIDTH'($urandom);
    phase_height[4] = '1;
    phase_offset[5] = COORD_WIDTH'($urandom);
    phase_height[5] = COORD_WIDTH'($urandom);
    phase_offset[6] = '1;
    phase_height[6] = COORD_WIDTH'($urandom);
    phase_offset[7] = COORD_WIDTH'($urandom);
    phase_height[7] = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        write_reg(CFG_Y_OFFSET, phase_offset[ph]);
        write_reg(CFG_LASER_HEIGHT, phase_height[ph]);
        if (ph == 2) begin
          write_reg(CFG_SPARE_IDX, COORD_WIDTH'($urandom));
          write_reg(CFG_TOP_IDX, COORD_WIDTH'($urandom));
        end
      end
      steady_source = (ph == 2 || ph == 3);
      steady_sink   = (ph == 3);
      if (ph == 2) hold_off_req = 1'b1;
      if (ph == 0) begin
        for (int k = 0; k < N_DIRECTED; k++) begin
          p.x_coord = COORD_WIDTH'(dir_x[k]);
          p.y_coord = COORD_WIDTH'(dir_y[k]);
          send_point(p);
        end
      end
      repeat (POINTS_PER_PHASE) send_point(random_point(phase_offset[ph]));
    end

    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
